/* hw/rtl/rbdpd_pkg.sv */
// Shared types and constants for the raw block delta pixel decoder.
`timescale 1ns / 1ps

package rbdpd_pkg;

    // Block geometry
    localparam int unsigned NUM_PIX   = 11;
    localparam int unsigned PIX_IDX_W = 4;
    localparam int unsigned RAW_W     = 14;   // leading values are 14 bits
    localparam int unsigned DELTA_W   = 10;   // later values are 10 bits
    localparam int unsigned CODE_W    = 2;
    localparam int unsigned SHIFT_W   = 3;
    localparam int unsigned RUN_W     = 20;   // running values stay below 2^20
    localparam int unsigned OUT_W     = 16;

    localparam logic [PIX_IDX_W-1:0] LAST_IDX = PIX_IDX_W'(NUM_PIX - 1);

    // Scale code that selects a shift of four instead of the code itself
    localparam logic [CODE_W-1:0]  CODE_SHIFT4 = 2'd3;
    localparam logic [SHIFT_W-1:0] SHIFT_FOUR  = 3'd4;

    // Arithmetic constants
    localparam logic [RUN_W-1:0] BASE_UNIT = 20'h00200;
    localparam logic [RUN_W-1:0] OFFSET    = 20'h0000f;
    localparam logic [OUT_W-1:0] OUT_SAT   = 16'h3fff;

    // One pixel as handed from the sequencer to the arithmetic pipeline
    typedef struct packed {
        logic [RAW_W-1:0]     e;
        logic [CODE_W-1:0]    code;
        logic [PIX_IDX_W-1:0] index;
        logic                 last;
    } t_pix;

endpackage

/* hw/rtl/rbdpd_pipe.sv */
// Three-stage arithmetic pipeline: scale, running-value update, offset and clamp.
`timescale 1ns / 1ps

module rbdpd_pipe (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  rbdpd_pkg::t_pix                   i_pix,
    output logic                              o_valid,
    output logic [rbdpd_pkg::OUT_W-1:0]       o_pixel_value,
    output logic [rbdpd_pkg::PIX_IDX_W-1:0]   o_pixel_index,
    output logic                              o_last_pixel
);

    // ---------------- stage 1: shift and base ----------------
    logic [rbdpd_pkg::SHIFT_W-1:0]   shamt;
    logic                            r1_valid;
    logic [rbdpd_pkg::RAW_W-1:0]     r1_eraw;
    logic [rbdpd_pkg::RAW_W-1:0]     r1_esh;
    logic [rbdpd_pkg::RUN_W-1:0]     r1_base;
    logic                            r1_add_ok;
    logic                            r1_first;
    logic [rbdpd_pkg::PIX_IDX_W-1:0] r1_index;
    logic                            r1_last;

    // code 3 means shift by four
    assign shamt = (i_pix.code == rbdpd_pkg::CODE_SHIFT4) ? rbdpd_pkg::SHIFT_FOUR
                                                          : rbdpd_pkg::SHIFT_W'(i_pix.code);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_eraw   <= i_pix.e;
        r1_esh    <= rbdpd_pkg::RAW_W'(i_pix.e[rbdpd_pkg::DELTA_W-1:0]) << shamt;
        r1_base   <= rbdpd_pkg::BASE_UNIT << shamt;
        r1_add_ok <= (i_pix.code != rbdpd_pkg::CODE_SHIFT4);   // base below 0x2000
        r1_first  <= (i_pix.index[rbdpd_pkg::PIX_IDX_W-1:1] == '0);
        r1_index  <= i_pix.index;
        r1_last   <= i_pix.last;
    end

    // ---------------- stage 2: per-parity running value ----------------
    logic [rbdpd_pkg::RUN_W-1:0]     r_run [2];
    logic                            r_seen [2];
    logic                            par;
    logic                            seen_p;
    logic [rbdpd_pkg::RUN_W-1:0]     run_p;
    logic [rbdpd_pkg::RUN_W-1:0]     excess;
    logic [rbdpd_pkg::RUN_W-1:0]     v;
    logic                            seen_nx;
    logic                            r2_valid;
    logic [rbdpd_pkg::RUN_W-1:0]     r2_v;
    logic [rbdpd_pkg::PIX_IDX_W-1:0] r2_index;
    logic                            r2_last;

    // the previous pixel of the same parity is already past this stage, so its update is already stored
    always_comb begin
        par    = r1_index[0];
        seen_p = r1_first ? 1'b0 : r_seen[par];
        run_p  = r1_first ? '0 : r_run[par];
        excess = (r1_add_ok && (run_p > r1_base)) ? (run_p - r1_base) : '0;
        if (seen_p) begin
            v       = rbdpd_pkg::RUN_W'(r1_esh) + excess;
            seen_nx = 1'b1;
        end else if (r1_eraw != '0) begin
            v       = rbdpd_pkg::RUN_W'(r1_eraw);
            seen_nx = 1'b1;
        end else begin
            v       = run_p;
            seen_nx = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid) begin
            r_run[par]  <= v;
            r_seen[par] <= seen_nx;
        end
        r2_v     <= v;
        r2_index <= r1_index;
        r2_last  <= r1_last;
    end

    // ---------------- stage 3: offset removal and clamp ----------------
    logic [rbdpd_pkg::RUN_W-1:0] diff;
    logic [rbdpd_pkg::OUT_W-1:0] pix_out;
    logic                        r3_valid;

    always_comb begin
        diff = r2_v - rbdpd_pkg::OFFSET;
        if (r2_v < rbdpd_pkg::OFFSET) begin
            pix_out = '0;
        end else if (diff[rbdpd_pkg::RUN_W-1:rbdpd_pkg::OUT_W] != '0) begin
            pix_out = rbdpd_pkg::OUT_SAT;
        end else begin
            pix_out = diff[rbdpd_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_pixel_value <= pix_out;
        o_pixel_index <= r2_index;
        o_last_pixel  <= r2_last;
    end

    assign o_valid = r3_valid;

endmodule

/* hw/rtl/raw_block_delta_pixel_decode_top.sv */
// Top level of the raw block delta pixel decoder: block sequencer and pipeline.
`timescale 1ns / 1ps

// A block of 16 bytes is taken on a rising edge with start high and busy low.
// It yields 11 pixels, one per cycle, on o_pixel_value / o_pixel_index with
// o_pixel_valid high for exactly one cycle each and o_last_pixel on pixel 10;
// results cannot be held off. Pixel 0 passes through the scale, running-value
// and clamp stages after the accepting edge and the rest follow back to back.
// The block sequencer issues one pixel per cycle; busy falls while the last
// pixel is issued, so a new block can follow with no gap in the pixel stream.

module raw_block_delta_pixel_decode_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [63:0]                       i_block_low,
    input  logic [63:0]                       i_block_high,
    output logic                              o_pixel_valid,
    output logic [rbdpd_pkg::OUT_W-1:0]       o_pixel_value,
    output logic [rbdpd_pkg::PIX_IDX_W-1:0]   o_pixel_index,
    output logic                              o_last_pixel
);

    logic [127:0]                    blk_word;
    logic                            accept;
    logic [rbdpd_pkg::RAW_W-1:0]     ld_e    [rbdpd_pkg::NUM_PIX];
    logic [rbdpd_pkg::CODE_W-1:0]    ld_code [rbdpd_pkg::NUM_PIX];
    logic [rbdpd_pkg::RAW_W-1:0]     r_e     [rbdpd_pkg::NUM_PIX];
    logic [rbdpd_pkg::CODE_W-1:0]    r_code  [rbdpd_pkg::NUM_PIX];
    logic                            r_active;
    logic [rbdpd_pkg::PIX_IDX_W-1:0] r_pix;
    rbdpd_pkg::t_pix                 issue;

    // Bitstream runs from byte 15 bit 7 downward
    always_comb begin
        blk_word    = {i_block_high, i_block_low};
        ld_e[0]     = blk_word[127:114];
        ld_e[1]     = blk_word[113:100];
        ld_e[2]     = rbdpd_pkg::RAW_W'(blk_word[97:88]);
        ld_e[3]     = rbdpd_pkg::RAW_W'(blk_word[87:78]);
        ld_e[4]     = rbdpd_pkg::RAW_W'(blk_word[77:68]);
        ld_e[5]     = rbdpd_pkg::RAW_W'(blk_word[65:56]);
        ld_e[6]     = rbdpd_pkg::RAW_W'(blk_word[55:46]);
        ld_e[7]     = rbdpd_pkg::RAW_W'(blk_word[45:36]);
        ld_e[8]     = rbdpd_pkg::RAW_W'(blk_word[33:24]);
        ld_e[9]     = rbdpd_pkg::RAW_W'(blk_word[23:14]);
        ld_e[10]    = rbdpd_pkg::RAW_W'(blk_word[13:4]);
        // scale codes precede pixels 2, 5 and 8
        ld_code[0]  = '0;
        ld_code[1]  = '0;
        ld_code[2]  = blk_word[99:98];
        ld_code[3]  = blk_word[99:98];
        ld_code[4]  = blk_word[99:98];
        ld_code[5]  = blk_word[67:66];
        ld_code[6]  = blk_word[67:66];
        ld_code[7]  = blk_word[67:66];
        ld_code[8]  = blk_word[35:34];
        ld_code[9]  = blk_word[35:34];
        ld_code[10] = blk_word[35:34];
    end

    assign busy   = r_active && (r_pix != rbdpd_pkg::LAST_IDX);
    assign accept = start && !busy;

    // Sequencer control: one pixel issued per active cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pix    <= '0;
        end else if (accept) begin
            r_active <= 1'b1;
            r_pix    <= '0;
        end else if (r_active) begin
            if (r_pix == rbdpd_pkg::LAST_IDX) begin
                r_active <= 1'b0;
            end else begin
                r_pix <= r_pix + 1'b1;
            end
        end
    end

    // Pixel fields shift toward slot 0, which feeds the pipeline
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < rbdpd_pkg::NUM_PIX; i++) begin
                r_e[i]    <= ld_e[i];
                r_code[i] <= ld_code[i];
            end
        end else begin
            for (int i = 0; i < rbdpd_pkg::NUM_PIX - 1; i++) begin
                r_e[i]    <= r_e[i+1];
                r_code[i] <= r_code[i+1];
            end
        end
    end

    always_comb begin
        issue.e     = r_e[0];
        issue.code  = r_code[0];
        issue.index = r_pix;
        issue.last  = (r_pix == rbdpd_pkg::LAST_IDX);
    end

    rbdpd_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_active),
        .i_pix         (issue),
        .o_valid       (o_pixel_valid),
        .o_pixel_value (o_pixel_value),
        .o_pixel_index (o_pixel_index),
        .o_last_pixel  (o_last_pixel)
    );

    // ---------------- assertions ----------------
    // First pixel of a block reaches the output after its transfer
    a_first_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##3 (o_pixel_valid && (o_pixel_index == '0)))
        else $error("pixel 0 not delivered three cycles after block transfer");

    // Pixels of a block come out consecutively
    a_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel_valid && (o_pixel_index != '0)) |->
            ($past(o_pixel_valid) &&
             ($past(o_pixel_index) == (o_pixel_index - 1'b1))))
        else $error("pixel index sequence broken");

    // Last marker only on the final pixel
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel_valid |-> (o_last_pixel == (o_pixel_index == rbdpd_pkg::LAST_IDX)))
        else $error("last pixel marker mismatch");

endmodule
